// ===== design/osb_pkg.sv =====
// Package for the ordered sequence buffer.
// Holds the payload structs, cell control struct, state enum and code constants.
// No dependencies.
package osb_pkg;

    localparam int WORD_W  = 32;
    localparam int POS_W   = 5;
    localparam int FILL_W  = 5;
    localparam int STAT_W  = 2;
    localparam int OP_W    = 3;
    // wide enough for any cell index or fill count up to 511
    localparam int INDEX_W = 9;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_PREPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS  = 2'd2;
    localparam logic [STAT_W-1:0] ST_CLIPPED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] run_length;
        t_word            word_in;
    } t_op_item;

    typedef struct packed {
        t_word             word_out;
        logic [FILL_W-1:0] fill;
        logic [STAT_W-1:0] status;
    } t_result;

    // Broadcast to every cell in the row
    typedef struct packed {
        logic               shift_up;
        logic               shift_down;
        logic [INDEX_W-1:0] pos;
        t_word              word;
    } t_cell_ctrl;

    typedef enum logic {
        S_IDLE,
        S_ERASE
    } t_state;

endpackage

// ===== design/osb_cell.sv =====
// One storage cell of the ordered sequence buffer row.
// Depends on osb_pkg for the cell control struct and word type.
module osb_cell #(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  osb_pkg::t_cell_ctrl i_ctrl,
    input  osb_pkg::t_word      i_left,
    input  osb_pkg::t_word      i_right,
    output osb_pkg::t_word      o_word
);

    localparam int IW = osb_pkg::INDEX_W;
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    osb_pkg::t_word r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_up) begin
            // open a gap at pos: cells above take their lower neighbour
            if (MY_IDX > i_ctrl.pos) begin
                r_word <= i_left;
            end else if (MY_IDX == i_ctrl.pos) begin
                r_word <= i_ctrl.word;
            end
        end else if (i_ctrl.shift_down) begin
            // close one place at pos
            if (MY_IDX >= i_ctrl.pos) begin
                r_word <= i_right;
            end
        end
    end

    assign o_word = r_word;

endmodule

// ===== design/osb_ctrl.sv =====
// Sequencer for the ordered sequence buffer: fill count, erase stepping,
// status and the output register pair. Depends on osb_pkg.
module osb_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  osb_pkg::t_op_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output osb_pkg::t_result    o_result,
    input  osb_pkg::t_word      i_rd_word,
    output osb_pkg::t_cell_ctrl o_cell_ctrl
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = osb_pkg::INDEX_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    osb_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_pos, n_pos;
    logic [4:0]       r_left, n_left;
    logic [1:0]       r_status, n_status;
    logic             r_out_valid;
    osb_pkg::t_result r_out;
    logic             r_hold_valid;
    osb_pkg::t_result r_hold;

    logic             w_accept;
    logic             w_full;
    logic [IW-1:0]    w_pos_x;
    logic [IW-1:0]    w_cnt_x;
    logic [IW-1:0]    w_run_x;
    logic [IW-1:0]    w_avail;
    logic             w_erase_bad;
    logic             w_erase_clip;
    logic [4:0]       w_erase_run;
    logic             w_erase_start;
    logic             w_res_fire;
    osb_pkg::t_result w_res;
    logic             w_out_free;

    function automatic logic [osb_pkg::FILL_W-1:0] FILL_W_CAST(input logic [CW-1:0] c);
        FILL_W_CAST = osb_pkg::FILL_W'(c);
    endfunction

    // Decode of the offered item
    always_comb begin
        w_accept     = i_in_valid && o_in_ready;
        w_full       = (r_count == CAP_C);
        w_pos_x      = IW'(i_in_item.position);
        w_cnt_x      = IW'(r_count);
        w_run_x      = IW'(i_in_item.run_length);
        w_avail      = w_cnt_x - w_pos_x;
        w_erase_bad  = (w_pos_x >= w_cnt_x);
        w_erase_clip = !w_erase_bad && (w_run_x > w_avail);
        // clipping only happens when the room left is below a 5-bit run
        w_erase_run  = w_erase_clip ? w_avail[4:0] : i_in_item.run_length;
        w_erase_start = w_accept && (i_in_item.operation == osb_pkg::OP_ERASE)
                        && !w_erase_bad && (w_erase_run != 5'd0);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            osb_pkg::S_IDLE: begin
                if (w_erase_start) begin
                    n_state = osb_pkg::S_ERASE;
                end
            end
            osb_pkg::S_ERASE: begin
                if (r_left == 5'd1) begin
                    n_state = osb_pkg::S_IDLE;
                end
            end
            default: n_state = osb_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath next values
    always_comb begin
        o_in_ready  = 1'b0;
        o_cell_ctrl = '0;
        n_count     = r_count;
        n_pos       = r_pos;
        n_left      = r_left;
        n_status    = r_status;
        w_res_fire  = 1'b0;
        w_res       = '0;
        case (r_state)
            osb_pkg::S_IDLE: begin
                o_in_ready = !r_hold_valid;
                if (w_accept) begin
                    w_res_fire    = 1'b1;
                    w_res.status  = osb_pkg::ST_OK;
                    case (i_in_item.operation)
                        osb_pkg::OP_APPEND: begin
                            if (w_full) begin
                                w_res.status = osb_pkg::ST_FULL;
                            end else begin
                                o_cell_ctrl.shift_up = 1'b1;
                                o_cell_ctrl.pos      = w_cnt_x;
                                o_cell_ctrl.word     = i_in_item.word_in;
                                n_count              = r_count + 1'b1;
                            end
                        end
                        osb_pkg::OP_PREPEND: begin
                            if (w_full) begin
                                w_res.status = osb_pkg::ST_FULL;
                            end else begin
                                o_cell_ctrl.shift_up = 1'b1;
                                o_cell_ctrl.pos      = '0;
                                o_cell_ctrl.word     = i_in_item.word_in;
                                n_count              = r_count + 1'b1;
                            end
                        end
                        osb_pkg::OP_INSERT: begin
                            if (w_pos_x > w_cnt_x) begin
                                w_res.status = osb_pkg::ST_BADPOS;
                            end else if (w_full) begin
                                w_res.status = osb_pkg::ST_FULL;
                            end else begin
                                o_cell_ctrl.shift_up = 1'b1;
                                o_cell_ctrl.pos      = w_pos_x;
                                o_cell_ctrl.word     = i_in_item.word_in;
                                n_count              = r_count + 1'b1;
                            end
                        end
                        osb_pkg::OP_ERASE: begin
                            if (w_erase_bad) begin
                                w_res.status = osb_pkg::ST_BADPOS;
                            end else begin
                                w_res.status = w_erase_clip ? osb_pkg::ST_CLIPPED
                                                            : osb_pkg::ST_OK;
                                n_status     = w_res.status;
                                n_pos        = w_pos_x;
                                n_left       = w_erase_run;
                                // a non-empty run reports when its last step is done
                                w_res_fire   = !w_erase_start;
                            end
                        end
                        osb_pkg::OP_READ: begin
                            if (w_erase_bad) begin
                                w_res.status = osb_pkg::ST_BADPOS;
                            end else begin
                                w_res.word_out = i_rd_word;
                            end
                        end
                        osb_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    w_res.fill = FILL_W_CAST(n_count);
                end
            end
            osb_pkg::S_ERASE: begin
                o_cell_ctrl.shift_down = 1'b1;
                o_cell_ctrl.pos        = r_pos;
                n_count                = r_count - 1'b1;
                n_left                 = r_left - 5'd1;
                if (r_left == 5'd1) begin
                    w_res_fire   = 1'b1;
                    w_res.status = r_status;
                    w_res.fill   = FILL_W_CAST(n_count);
                end
            end
            default: begin
            end
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= osb_pkg::S_IDLE;
            r_count      <= '0;
            r_left       <= '0;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (w_out_free) begin
                // older held result goes out first
                if (r_hold_valid) begin
                    r_out_valid  <= 1'b1;
                    r_hold_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_res_fire;
                end
            end else if (w_res_fire) begin
                r_hold_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_status <= n_status;
        if (w_out_free) begin
            r_out <= r_hold_valid ? r_hold : w_res;
        end else if (w_res_fire) begin
            r_hold <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("fill count above capacity");

    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> r_out_valid)
        else $error("held result without a pending output");

    a_erase_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == osb_pkg::S_ERASE) |-> (r_left != 5'd0) && (r_count != '0))
        else $error("erase step with nothing left to remove");

    a_no_result_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_fire && r_hold_valid))
        else $error("new result while one is held");

    a_erase_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == osb_pkg::S_ERASE) |-> !o_in_ready)
        else $error("input taken during an erase run");
`endif

endmodule

// ===== design/ordered_sequence_buffer.sv =====
// Ordered sequence buffer: a fixed-capacity ordered array of signed words.
// Input channel i_in_valid / o_in_ready carries one operation (append,
// prepend, insert, erase run, read, clear); output channel o_out_valid /
// i_out_ready carries one result (read word, fill after the operation,
// status) per operation, in order. A transfer happens when valid and ready
// are both high at a rising edge.
// Elements live in a row of CAPACITY cells; insert moves every cell above the
// position up by one at once, erase moves them down one place per cycle.
// The result of every operation is registered from its input transfer, except
// for a non-empty erase (run after clipping), which reports once the cell row
// has shifted down its last place. One operation is taken per cycle otherwise,
// until a waiting result fills the hold register.
// The result register is backed by a one-entry hold register, so one further
// operation is taken while a result waits; after that input ready drops until
// the receiver takes a transfer.
// Reset (synchronous, active low) empties the buffer and both output
// registers; stored words are not cleared and are never visible.
// Depends on osb_pkg, osb_cell and osb_ctrl.
module ordered_sequence_buffer #(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  osb_pkg::t_op_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output osb_pkg::t_result  o_result
);

    // positions are 5 bits wide, so only the first 32 cells are ever read
    localparam int RDN = (CAPACITY < 32) ? CAPACITY : 32;

    osb_pkg::t_word      w_word [CAPACITY];
    osb_pkg::t_word      w_rd_word;
    osb_pkg::t_cell_ctrl w_cell_ctrl;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            osb_pkg::t_word w_left;
            osb_pkg::t_word w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_word[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_word[g+1];
            end
            osb_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_cell_ctrl),
                .i_left  (w_left),
                .i_right (w_right),
                .o_word  (w_word[g])
            );
        end
    endgenerate

    always_comb begin
        w_rd_word = '0;
        for (int i = 0; i < RDN; i++) begin
            if (i_in_item.position == osb_pkg::POS_W'(i)) begin
                w_rd_word = w_word[i];
            end
        end
    end

    osb_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result),
        .i_rd_word   (w_rd_word),
        .o_cell_ctrl (w_cell_ctrl)
    );

endmodule
